FILE: hdl/lfrc_pkg.sv
// lfrc_pkg: shared types, constants and the check table of the lamp frame receiver
// no dependencies
package lfrc_pkg;

  localparam int FRAME_BYTES_DEF = 11;
  localparam int POS_W           = 4;
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] HDR0          = 8'hC8;
  localparam logic [7:0] HDR1          = 8'h8B;
  localparam logic [7:0] SPECIAL_CHECK = 8'hD5;
  localparam logic [7:0] SPECIAL_CMD   = 8'h06;

  localparam logic [7:0] DAYTIME_DUTY_RST  = 8'd201;
  localparam logic [7:0] POSITION_DUTY_RST = 8'd47;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMP_SIDE     = 3'd0,
    CFG_DAYTIME_DUTY  = 3'd1,
    CFG_POSITION_DUTY = 3'd2,
    CFG_TIMEOUT_TICKS = 3'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_APPLIED  = 3'd1,
    EV_SPECIAL  = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_REJECTED = 3'd4
  } event_t;

  typedef struct packed {
    logic       lamp_side;
    logic [7:0] daytime_duty;
    logic [7:0] position_duty;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       high_beam;
    logic       low_beam;
    logic       aux_lamp;
    logic       strip_mode;
    logic [7:0] pwm_duty;
  } lamps_t;

  typedef struct packed {
    logic [POS_W-1:0] frame_position;
    logic [7:0]       command_byte;
    logic [7:0]       turn_byte;
    logic [7:0]       tick_count;
    lamps_t           lamps;
  } state_t;

  typedef struct packed {
    lamps_t lamps;
    event_t ev;
  } result_t;

  // check word for each 6-bit lamp index
  function automatic logic [7:0] check_word(input logic [5:0] idx);
    logic [7:0] w;
    begin
      case (idx)
        6'd0:  w = 8'h4C; 6'd1:  w = 8'h9F; 6'd2:  w = 8'hED; 6'd3:  w = 8'h3E;
        6'd4:  w = 8'h9A; 6'd8:  w = 8'h27; 6'd12: w = 8'hF1; 6'd13: w = 8'hA0;
        6'd14: w = 8'hD2; 6'd15: w = 8'h01; 6'd16: w = 8'hB1; 6'd17: w = 8'h5D;
        6'd18: w = 8'h2F; 6'd19: w = 8'hFC; 6'd20: w = 8'h67; 6'd24: w = 8'hDA;
        6'd28: w = 8'h0C; 6'd29: w = 8'h62; 6'd30: w = 8'h10; 6'd31: w = 8'hC3;
        6'd32: w = 8'hFA; 6'd33: w = 8'hFE; 6'd34: w = 8'h8C; 6'd35: w = 8'h5F;
        6'd36: w = 8'h2C; 6'd40: w = 8'h91; 6'd41: w = 8'hEB; 6'd42: w = 8'h99;
        6'd43: w = 8'h4A; 6'd44: w = 8'h47; 6'd45: w = 8'hC1; 6'd46: w = 8'hB3;
        6'd47: w = 8'h60; 6'd48: w = 8'h07; 6'd49: w = 8'h3C; 6'd50: w = 8'h4E;
        6'd51: w = 8'h9D; 6'd52: w = 8'hD1; 6'd56: w = 8'h6C; 6'd60: w = 8'hBA;
        6'd61: w = 8'h03; 6'd62: w = 8'h71; 6'd63: w = 8'hA2;
        default: w = 8'h00;
      endcase
      return w;
    end
  endfunction

endpackage

FILE: hdl/lamp_frame_receiver_controller_unit.sv
// lamp_frame_receiver_controller_unit: top level of the lamp frame receiver
// depends on lfrc_pkg, lfrc_eval, lfrc_out_buf
// a word taken into the input register is evaluated combinationally and its
//   result word is registered in the output buffer, where it can be taken
// throughput: one word per cycle while the skid entry is free, set by the
//   single evaluation stage between the input and the result register
// reset (synchronous, rst_n low): frame search restarts, tick count cleared,
//   all lamps off with duty zero, registers back to side 0, duties 201 and 47,
//   timeout 200 ticks; buffered words are dropped
module lamp_frame_receiver_controller_unit import lfrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [7:0]           in_byte_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_high_beam,
  output logic                 out_low_beam,
  output logic                 out_aux_lamp,
  output logic                 out_strip_mode,
  output logic [7:0]           out_pwm_duty,
  output logic [2:0]           out_event_res,
  // register write port
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  op_t        s1_op_r;
  logic [7:0] s1_byte_r;

  // frame, tick and lamp state
  state_t state_r, state_nxt;
  cfg_t   cfg_r;

  event_t  ev;
  result_t res_word;
  result_t out_word;
  logic    buf_full;
  logic    fire;
  logic    in_take;

  // the input register stalls only while the skid entry is occupied
  assign in_stall = s1_valid_r && buf_full;
  assign in_take  = in_valid && !in_stall;
  assign fire     = s1_valid_r && !buf_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_take) begin
      s1_op_r   <= op_t'(in_op);
      s1_byte_r <= in_byte_value;
    end
  end

  // register writes are always taken at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lamp_side     <= 1'b0;
      cfg_r.daytime_duty  <= DAYTIME_DUTY_RST;
      cfg_r.position_duty <= POSITION_DUTY_RST;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LAMP_SIDE:     cfg_r.lamp_side     <= cfg_data[0];
        CFG_DAYTIME_DUTY:  cfg_r.daytime_duty  <= cfg_data;
        CFG_POSITION_DUTY: cfg_r.position_duty <= cfg_data;
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        default: ;  // indexes beyond the register list are ignored
      endcase
    end
  end

  // header search, byte capture, check table and lamp map
  lfrc_eval #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_eval (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .op        (s1_op_r),
    .byte_value(s1_byte_r),
    .state_nxt (state_nxt),
    .ev        (ev)
  );

  // state moves on only when the word is actually evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // every word yields the lamp state after it plus its event code
  assign res_word.lamps = state_nxt.lamps;
  assign res_word.ev    = ev;

  lfrc_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fire),
    .wr_word (res_word),
    .full    (buf_full),
    .rd_valid(out_valid),
    .rd_word (out_word),
    .rd_stall(out_stall)
  );

  assign out_high_beam  = out_word.lamps.high_beam;
  assign out_low_beam   = out_word.lamps.low_beam;
  assign out_aux_lamp   = out_word.lamps.aux_lamp;
  assign out_strip_mode = out_word.lamps.strip_mode;
  assign out_pwm_duty   = out_word.lamps.pwm_duty;
  assign out_event_res  = out_word.ev;

endmodule

FILE: hdl/lfrc_eval.sv
// lfrc_eval: next state and result word for one byte or tick
// depends on lfrc_pkg
module lfrc_eval import lfrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  state_t     state_cur,
  input  cfg_t       cfg,
  input  op_t        op,
  input  logic [7:0] byte_value,
  output state_t     state_nxt,
  output event_t     ev
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CMD  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TURN = POS_W'(3);

  logic [7:0] tick_inc;
  logic [7:0] cmd_eff;
  logic [7:0] turn_eff;
  logic [5:0] idx;
  logic [3:0] sel;
  logic       own_turn;
  logic       is_special;
  logic       check_ok;
  logic [POS_W-1:0] p;

  assign p        = state_cur.frame_position;
  assign tick_inc = state_cur.tick_count + 8'd1;
  // command/turn as they stand once this byte is stored
  assign cmd_eff  = (p == POS_CMD)  ? byte_value : state_cur.command_byte;
  assign turn_eff = (p == POS_TURN) ? byte_value : state_cur.turn_byte;
  assign idx      = {cmd_eff[2], cmd_eff[3], cmd_eff[4], cmd_eff[5], turn_eff[5], turn_eff[6]};
  assign sel      = {cmd_eff[5], cmd_eff[4], cmd_eff[3], cmd_eff[2]};
  assign own_turn = cfg.lamp_side ? turn_eff[5] : turn_eff[6];
  assign is_special = (cmd_eff == SPECIAL_CMD) && (byte_value == SPECIAL_CHECK);
  assign check_ok   = (byte_value == check_word(idx));

  always_comb begin
    state_nxt = state_cur;
    ev        = EV_NONE;
    if (op == OP_TICK) begin
      state_nxt.tick_count = tick_inc;
      if (tick_inc >= cfg.timeout_ticks) begin
        state_nxt.tick_count       = 8'd0;
        state_nxt.lamps.aux_lamp   = 1'b1;
        state_nxt.lamps.high_beam  = 1'b0;
        state_nxt.lamps.low_beam   = 1'b1;
        state_nxt.lamps.strip_mode = 1'b1;
        state_nxt.lamps.pwm_duty   = cfg.position_duty;
        ev = EV_TIMEOUT;
      end
    end else if (p > LAST_POS) begin
      state_nxt.frame_position = '0;
    end else if (p == '0) begin
      state_nxt.frame_position = (byte_value == HDR0) ? POS_W'(1) : '0;
    end else if (p == POS_W'(1)) begin
      state_nxt.frame_position = (byte_value == HDR1) ? POS_W'(2) : '0;
    end else begin
      state_nxt.command_byte = cmd_eff;
      state_nxt.turn_byte    = turn_eff;
      if (p == LAST_POS) begin
        state_nxt.frame_position = '0;
        if (is_special) begin
          state_nxt.lamps.aux_lamp   = 1'b1;
          state_nxt.lamps.low_beam   = 1'b0;
          state_nxt.lamps.high_beam  = 1'b0;
          state_nxt.lamps.strip_mode = 1'b1;
          state_nxt.lamps.pwm_duty   = cfg.position_duty;
          state_nxt.tick_count       = 8'd0;
          ev = EV_SPECIAL;
        end else if (!check_ok) begin
          ev = EV_REJECTED;
        end else begin
          state_nxt.tick_count     = 8'd0;
          state_nxt.lamps.aux_lamp = cmd_eff[2];
          case (sel)
            4'd0, 4'd4, 4'd6, 4'd8, 4'd12, 4'd13: begin
              state_nxt.lamps.pwm_duty = 8'd0;
            end
            4'd1, 4'd5, 4'd7, 4'd9, 4'd14, 4'd15: begin
              state_nxt.lamps.strip_mode = 1'b1;
              state_nxt.lamps.pwm_duty   = cfg.position_duty;
            end
            default: begin
              state_nxt.lamps.strip_mode = 1'b0;
              state_nxt.lamps.pwm_duty   = own_turn ? 8'd0 : cfg.daytime_duty;
            end
          endcase
          state_nxt.lamps.low_beam  = (sel inside {[4'd4:4'd7]}) || (sel >= 4'd12);
          state_nxt.lamps.high_beam = (sel == 4'd8) || (sel >= 4'd12);
          ev = EV_APPLIED;
        end
      end else begin
        state_nxt.frame_position = p + POS_W'(1);
      end
    end
  end

endmodule

FILE: hdl/lfrc_out_buf.sv
// lfrc_out_buf: result register with a skid entry behind it
// depends on lfrc_pkg
module lfrc_out_buf import lfrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_word,
  output logic    full,
  output logic    rd_valid,
  output result_t rd_word,
  input  logic    rd_stall
);

  logic    o_valid_r, o_valid_nxt;
  logic    sk_valid_r, sk_valid_nxt;
  result_t o_word_r, o_word_nxt;
  result_t sk_word_r, sk_word_nxt;

  always_comb begin
    o_valid_nxt  = o_valid_r;
    sk_valid_nxt = sk_valid_r;
    o_word_nxt   = o_word_r;
    sk_word_nxt  = sk_word_r;
    if (sk_valid_r) begin
      if (!rd_stall) begin
        o_word_nxt   = sk_word_r;
        sk_valid_nxt = 1'b0;
      end
    end else if (wr_en) begin
      if (o_valid_r && rd_stall) begin
        sk_word_nxt  = wr_word;
        sk_valid_nxt = 1'b1;
      end else begin
        o_word_nxt  = wr_word;
        o_valid_nxt = 1'b1;
      end
    end else if (o_valid_r && !rd_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r  <= 1'b0;
      sk_valid_r <= 1'b0;
    end else begin
      o_valid_r  <= o_valid_nxt;
      sk_valid_r <= sk_valid_nxt;
    end
    o_word_r  <= o_word_nxt;
    sk_word_r <= sk_word_nxt;
  end

  assign full     = sk_valid_r;
  assign rd_valid = o_valid_r;
  assign rd_word  = o_word_r;

endmodule
